[hw/rtl/dkim_body_canonicalizer_defines.svh]
// Assertion macros for the DKIM body canonicalizer.
`ifndef DKIM_BODY_CANONICALIZER_DEFINES_SVH
`define DKIM_BODY_CANONICALIZER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DKBC_ASSERT_IMPLIES(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define DKBC_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

[hw/rtl/dkbc_pkg.sv]
// Shared types and constants of the DKIM body canonicalizer.
package dkbc_pkg;

    localparam int COUNT_FIELD_W      = 24;
    localparam int RUN_COUNT_BITS_DEF = 24;
    localparam int QUEUE_DEPTH_DEF    = 4;
    localparam int NUM_SLOTS          = 5;

    localparam logic [7:0] CR_BYTE    = 8'h0D;
    localparam logic [7:0] LF_BYTE    = 8'h0A;
    localparam logic [7:0] SPACE_BYTE = 8'h20;
    localparam logic [7:0] TAB_BYTE   = 8'h09;

    localparam int SLOT_RUN   = 0;
    localparam int SLOT_SPACE = 1;
    localparam int SLOT_CR    = 2;
    localparam int SLOT_DATA  = 3;
    localparam int SLOT_CLOSE = 4;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_RUN   = 2'd1,
        KIND_EMPTY = 2'd2
    } kind_t;

    typedef struct packed {
        logic [NUM_SLOTS-1:0]     mask;
        logic [COUNT_FIELD_W-1:0] count;
        logic [7:0]               data;
        logic                     close_empty;
        logic                     overflow;
    } cmd_t;

endpackage

[hw/rtl/dkim_body_canonicalizer.sv]
// DKIM body canonicalizer top level: front end, command queue, back end.
// Each result passes through the command queue and the back end's output register.
// Throughput: one input byte per cycle while the queue has room; the back end sends one
// result per cycle while m_tready is high, holding an item until all its results are sent.
// Reset (rst_n low, asynchronous): mode returns to simple, line state, overflow flag,
// queue and output valid flag clear.
module dkim_body_canonicalizer
    import dkbc_pkg::*;
#(
    parameter int RUN_COUNT_BITS = RUN_COUNT_BITS_DEF,
    parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tuser,    // [0] has_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [7:0] out_byte, [31:8] crlf_count, [32] run_overflow
    output logic [1:0]  m_tuser,    // [1:0] kind
    output logic        m_tlast
);

    `include "dkim_body_canonicalizer_defines.svh"

    cmd_t        push_cmd, head_cmd;
    logic        push, pop, q_full, q_empty;
    logic [7:0]  out_byte;
    logic [23:0] crlf_count;
    logic        run_overflow;

    dkbc_front #(
        .RUN_COUNT_BITS (RUN_COUNT_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .data_byte   (s_tdata),
        .has_byte    (s_tuser),
        .end_of_body (s_tlast),
        .q_full      (q_full),
        .push        (push),
        .cmd         (push_cmd)
    );

    dkbc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_cmd (push_cmd),
        .pop    (pop),
        .head   (head_cmd),
        .full   (q_full),
        .empty  (q_empty)
    );

    dkbc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head_cmd),
        .q_empty      (q_empty),
        .pop          (pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .kind         (m_tuser),
        .out_byte     (out_byte),
        .crlf_count   (crlf_count),
        .run_overflow (run_overflow),
        .last         (m_tlast)
    );

    assign m_tdata = {7'd0, run_overflow, crlf_count, out_byte};

    `DKBC_ASSERT_IMPLIES(a_close_not_byte, clk, rst_n, m_tvalid && m_tlast, m_tuser != KIND_BYTE, "closing result carries a byte")
    `DKBC_ASSERT_IMPLIES(a_empty_is_last, clk, rst_n, m_tvalid && (m_tuser == KIND_EMPTY), m_tlast, "empty marker not last")
    `DKBC_ASSERT_IMPLIES(a_run_nonzero, clk, rst_n, m_tvalid && (m_tuser == KIND_RUN), crlf_count != 24'd0, "empty CRLF run")
    `DKBC_ASSERT_NEXT(a_overflow_sticky, clk, rst_n, m_tvalid && m_tready && run_overflow, !m_tvalid || run_overflow, "overflow flag cleared")

endmodule

[hw/rtl/dkbc_front.sv]
// Front end: accepts body bytes, tracks line and whitespace state, builds result commands.
module dkbc_front
    import dkbc_pkg::*;
#(
    parameter int RUN_COUNT_BITS = RUN_COUNT_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       has_byte,
    input  logic       end_of_body,
    input  logic       q_full,
    output logic       push,
    output cmd_t       cmd
);

    localparam int HELD_W = (RUN_COUNT_BITS < COUNT_FIELD_W) ? RUN_COUNT_BITS : COUNT_FIELD_W;

    logic              mode_reg;
    logic              space_reg, space_next;
    logic              cr_reg, cr_next;
    logic              seen_reg, seen_next;
    logic              ovf_reg, ovf_next;
    logic [HELD_W-1:0] held_reg, held_next;

    logic accept;
    logic is_cr, is_lf, is_ws;
    logic lf_pair, flush_cr, ordinary, data_out, emits, sat;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        is_cr    = (data_byte == CR_BYTE);
        is_lf    = (data_byte == LF_BYTE);
        is_ws    = mode_reg && ((data_byte == SPACE_BYTE) || (data_byte == TAB_BYTE));
        lf_pair  = has_byte && is_lf && cr_reg;
        flush_cr = cr_reg && ((has_byte && !lf_pair) || (!has_byte && end_of_body));
        ordinary = has_byte && !lf_pair && !is_cr && !is_ws;
        data_out = ordinary || (has_byte && is_cr && end_of_body);
        emits    = flush_cr || data_out;
        sat      = &held_reg;
        ovf_next = ovf_reg || (lf_pair && sat);

        cmd.mask                = '0;
        cmd.mask[SLOT_RUN]      = emits && (held_reg != '0);
        cmd.mask[SLOT_SPACE]    = emits && space_reg;
        cmd.mask[SLOT_CR]       = flush_cr;
        cmd.mask[SLOT_DATA]     = data_out;
        cmd.mask[SLOT_CLOSE]    = end_of_body;
        cmd.count               = COUNT_FIELD_W'(held_reg);
        cmd.data                = data_byte;
        cmd.close_empty         = mode_reg && !(seen_reg || emits);
        cmd.overflow            = ovf_next;

        if (end_of_body)
        begin
            space_next = 1'b0;
            cr_next    = 1'b0;
            seen_next  = 1'b0;
            held_next  = '0;
        end
        else
        begin
            cr_next    = has_byte ? is_cr : cr_reg;
            seen_next  = seen_reg || emits;
            if (has_byte && is_ws)
                space_next = 1'b1;
            else if (lf_pair || emits)
                space_next = 1'b0;
            else
                space_next = space_reg;
            if (lf_pair)
                held_next = sat ? held_reg : held_reg + HELD_W'(1);
            else if (emits)
                held_next = '0;
            else
                held_next = held_reg;
        end
    end

    assign push = accept && (cmd.mask != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            space_reg <= 1'b0;
            cr_reg    <= 1'b0;
            seen_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
            held_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                mode_reg <= cfg_wr_data;
            if (accept)
            begin
                space_reg <= space_next;
                cr_reg    <= cr_next;
                seen_reg  <= seen_next;
                ovf_reg   <= ovf_next;
                held_reg  <= held_next;
            end
        end
    end

endmodule

[hw/rtl/dkbc_queue.sv]
// Command queue between front and back end, shifting toward the head.
module dkbc_queue
    import dkbc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t wr_cmd,
    input  logic pop,
    output cmd_t head,
    output logic full,
    output logic empty
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] wr_pos;

    assign head   = entry_reg[0];
    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);
    assign wr_pos = pop ? count_reg - CNT_W'(1) : count_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH - 1; i++)
        begin
            if (push && (wr_pos == CNT_W'(i)))
                entry_reg[i] <= wr_cmd;
            else if (pop)
                entry_reg[i] <= entry_reg[i+1];
        end
        if (push && (wr_pos == CNT_W'(DEPTH - 1)))
            entry_reg[DEPTH-1] <= wr_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (push && !pop)
            count_reg <= count_reg + CNT_W'(1);
        else if (pop && !push)
            count_reg <= count_reg - CNT_W'(1);
    end

endmodule

[hw/rtl/dkbc_back.sv]
// Back end: expands each command into result transfers through the output register.
module dkbc_back
    import dkbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        head,
    input  logic        q_empty,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  out_byte,
    output logic [23:0] crlf_count,
    output logic        run_overflow,
    output logic        last
);

    cmd_t                 cur_reg;
    cmd_t                 cur_next;
    cmd_t                 src;
    logic                 from_q;
    logic [NUM_SLOTS-1:0] src_mask, rest;
    logic                 out_free, fire;
    kind_t                kind_next;
    logic [7:0]           byte_next;
    logic [23:0]          count_next;
    logic                 last_next;

    logic                 valid_reg;
    kind_t                kind_reg;
    logic [7:0]           byte_reg;
    logic [23:0]          count_reg;
    logic                 ovf_reg;
    logic                 last_reg;

    always_comb
    begin
        from_q     = (cur_reg.mask == '0);
        src        = from_q ? head : cur_reg;
        src_mask   = from_q ? (q_empty ? '0 : head.mask) : cur_reg.mask;
        out_free   = !valid_reg || out_ready;
        fire       = out_free && (src_mask != '0);
        pop        = fire && from_q;
        rest       = src_mask;
        kind_next  = KIND_BYTE;
        byte_next  = '0;
        count_next = '0;
        last_next  = 1'b0;
        if (src_mask[SLOT_RUN])
        begin
            rest[SLOT_RUN] = 1'b0;
            kind_next      = KIND_RUN;
            count_next     = src.count;
        end
        else if (src_mask[SLOT_SPACE])
        begin
            rest[SLOT_SPACE] = 1'b0;
            byte_next        = SPACE_BYTE;
        end
        else if (src_mask[SLOT_CR])
        begin
            rest[SLOT_CR] = 1'b0;
            byte_next     = CR_BYTE;
        end
        else if (src_mask[SLOT_DATA])
        begin
            rest[SLOT_DATA] = 1'b0;
            byte_next       = src.data;
        end
        else
        begin
            rest[SLOT_CLOSE] = 1'b0;
            kind_next        = src.close_empty ? KIND_EMPTY : KIND_RUN;
            count_next       = src.close_empty ? 24'd0 : 24'd1;
            last_next        = 1'b1;
        end
        cur_next      = src;
        cur_next.mask = rest;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
                cur_reg <= cur_next;
            if (out_free)
                valid_reg <= fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            kind_reg  <= kind_next;
            byte_reg  <= byte_next;
            count_reg <= count_next;
            ovf_reg   <= src.overflow;
            last_reg  <= last_next;
        end
    end

    assign out_valid    = valid_reg;
    assign kind         = kind_reg;
    assign out_byte     = byte_reg;
    assign crlf_count   = count_reg;
    assign run_overflow = ovf_reg;
    assign last         = last_reg;

endmodule
